### sv/wbs_pkg.sv
// Shared constants, types and helper functions for the weighted 3x3 smoothing filter.
`timescale 1ns / 1ps
`default_nettype none

package wbs_pkg;

    // Pixel and channel geometry
    localparam int PixW    = 8;
    localparam int RgbW    = 3 * PixW;
    localparam int PosW    = 10;
    localparam int SideW   = 11;

    // Largest supported frame side and the column/row counter width
    localparam int MaxSide = 1024;
    localparam int ColW    = $clog2(MaxSide);

    // Ten 8-bit terms at most
    localparam int SumW    = 12;

    // Reciprocal constants: q = (sum * Recip) >> RecipShift
    localparam int RecipW     = 13;
    localparam int RecipShift = 15;
    localparam logic [RecipW-1:0] Recip5  = 13'd6554;
    localparam logic [RecipW-1:0] Recip7  = 13'd4682;
    localparam logic [RecipW-1:0] Recip10 = 13'd3277;

    // Configuration port
    localparam int ApbAddrW = 3;
    localparam int ApbDataW = 32;
    localparam int RegIdxW  = 1;
    localparam logic [RegIdxW-1:0] RegFrameSide   = 1'b0;
    localparam logic [SideW-1:0]   FrameSideReset = 11'd1024;

    // Neighbor count plus one for the smoothed pixel
    typedef enum logic [1:0] {
        DivBy5  = 2'b00,
        DivBy7  = 2'b01,
        DivBy10 = 2'b10
    } t_div;

    typedef logic [RgbW-1:0] t_pix;

    // One window of work handed from the line store stage to the result sequencer
    typedef struct packed {
        t_pix [2:0][2:0]  grid;    // grid[row][col], row 2 / col 2 newest
        logic [ColW-1:0]  row;     // raster row of the newest pixel
        logic [ColW-1:0]  col;     // raster column of the newest pixel
        logic [1:0]       row_ok;  // [0]: row r-2 in frame, [1]: row r-1 in frame
        logic [1:0]       col_ok;  // [0]: col c-2 in frame, [1]: col c-1 in frame
        logic [3:0]       mask;    // results this pixel completes, in output order
    } t_job;

    // Last row/column index for a programmed frame side, saturated to 2..MaxSide
    function automatic logic [ColW-1:0] side_last(logic [SideW-1:0] fs);
        logic [ColW-1:0] last;
        if (fs < SideW'(2)) begin
            last = ColW'(1);
        end else if (32'(fs) > 32'(MaxSide)) begin
            last = ColW'(MaxSide - 1);
        end else begin
            last = ColW'(fs - SideW'(1));
        end
        return last;
    endfunction

    // Truncating divide of a channel sum by 5, 7 or 10
    function automatic logic [PixW-1:0] div_sum(logic [SumW-1:0] s, t_div d);
        logic [RecipW-1:0]      m;
        logic [SumW+RecipW-1:0] p;
        unique case (d)
            DivBy5:  m = Recip5;
            DivBy7:  m = Recip7;
            DivBy10: m = Recip10;
            default: m = Recip10;
        endcase
        p = (SumW + RecipW)'(s) * (SumW + RecipW)'(m);
        return p[RecipShift +: PixW];
    endfunction

endpackage

`default_nettype wire

### sv/wbs_if.sv
// Valid/ready stream interfaces for input pixels and smoothed results.
`timescale 1ns / 1ps
`default_nettype none

interface wbs_pix_if;
    logic                       valid;
    logic                       ready;
    logic [wbs_pkg::PixW-1:0]   red_in;
    logic [wbs_pkg::PixW-1:0]   green_in;
    logic [wbs_pkg::PixW-1:0]   blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface wbs_res_if;
    logic                       valid;
    logic                       ready;
    logic [wbs_pkg::PixW-1:0]   red_out;
    logic [wbs_pkg::PixW-1:0]   green_out;
    logic [wbs_pkg::PixW-1:0]   blue_out;
    logic [wbs_pkg::PosW-1:0]   out_row;
    logic [wbs_pkg::PosW-1:0]   out_col;
    logic                       run_end;
    logic                       frame_end;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output out_row, output out_col, output run_end, output frame_end,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input out_row, input out_col, input run_end, input frame_end,
                    output ready);
endinterface

`default_nettype wire

### sv/wbs_window.sv
// Raster counters, two-line store memory and 3x3 window assembly.
`timescale 1ns / 1ps
`default_nettype none

module wbs_window (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [wbs_pkg::ColW-1:0]  i_last,
    input  wire logic                      i_restart,
    wbs_pix_if.sink                        i_pix,
    output wbs_pkg::t_job                  o_job,
    output logic                           o_job_valid,
    input  wire logic                      i_job_ready
);

    localparam int ColW = wbs_pkg::ColW;
    localparam int RgbW = wbs_pkg::RgbW;

    logic                  accept;
    logic                  s1_fire;

    logic [ColW-1:0]       r_row, n_row;
    logic [ColW-1:0]       r_col, n_col;

    logic                  r_s1_valid;
    wbs_pkg::t_pix         r_s1_pix;
    logic [ColW-1:0]       r_s1_row;
    logic [ColW-1:0]       r_s1_col;

    // Entry c holds {row r-1, row r-2} at column c
    logic [2*RgbW-1:0]     r_mem [wbs_pkg::MaxSide];
    logic [2*RgbW-1:0]     r_rd;

    wbs_pkg::t_pix         r_win [6];
    wbs_pkg::t_pix         top_pix;
    wbs_pkg::t_pix         mid_pix;

    // Take a pixel when the line store stage is empty or moving on
    assign i_pix.ready = !r_s1_valid || i_job_ready;
    assign accept      = i_pix.valid && i_pix.ready;
    assign s1_fire     = r_s1_valid && i_job_ready;

    // Advance the raster position
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_restart) begin
            n_row = '0;
            n_col = '0;
        end else if (accept) begin
            if (r_col == i_last) begin
                n_col = '0;
                n_row = (r_row == i_last) ? '0 : r_row + ColW'(1);
            end else begin
                n_col = r_col + ColW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_row      <= n_row;
            r_col      <= n_col;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Capture the accepted pixel and its position
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix <= {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
            r_s1_row <= r_row;
            r_s1_col <= r_col;
        end
    end

    // Line store: read on accept, write back the shifted column when the pixel moves on.
    // Reads are issued only on accept, so a stalled read word holds.
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_mem[r_s1_col] <= {r_s1_pix, r_rd[2*RgbW-1 -: RgbW]};
        end
        if (accept) begin
            r_rd <= r_mem[r_col];
        end
    end

    assign mid_pix = r_rd[2*RgbW-1 -: RgbW];
    assign top_pix = r_rd[RgbW-1:0];

    // Shift the window by one column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (s1_fire) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k] <= r_win[3 + k];
            end
            r_win[3] <= top_pix;
            r_win[4] <= mid_pix;
            r_win[5] <= r_s1_pix;
        end
    end

    // Assemble the job for the result sequencer
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_job.grid[k][0] = r_win[k];
            o_job.grid[k][1] = r_win[3 + k];
        end
        o_job.grid[0][2] = top_pix;
        o_job.grid[1][2] = mid_pix;
        o_job.grid[2][2] = r_s1_pix;
        o_job.row        = r_s1_row;
        o_job.col        = r_s1_col;
        o_job.row_ok[0]  = r_s1_row >= ColW'(2);
        o_job.row_ok[1]  = r_s1_row != '0;
        o_job.col_ok[0]  = r_s1_col >= ColW'(2);
        o_job.col_ok[1]  = r_s1_col != '0;
        o_job.mask[0]    = (r_s1_row != '0) && (r_s1_col != '0);
        o_job.mask[1]    = (r_s1_row != '0) && (r_s1_col == i_last);
        o_job.mask[2]    = (r_s1_row == i_last) && (r_s1_col != '0);
        o_job.mask[3]    = (r_s1_row == i_last) && (r_s1_col == i_last);
    end

    assign o_job_valid = r_s1_valid;

    // A stalled pixel keeps its position and its line store word
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !i_job_ready |=> r_s1_valid && $stable(r_s1_col) && $stable(r_rd))
        else $error("line store stage lost its word while stalled");

    // Raster position stays inside the frame
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= i_last) && (r_row <= i_last))
        else $error("raster counter beyond frame side");

endmodule

`default_nettype wire

### sv/wbs_emit.sv
// Result sequencer, per-channel window sums and reciprocal divide with output register.
`timescale 1ns / 1ps
`default_nettype none

module wbs_emit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire wbs_pkg::t_job  i_job,
    input  wire logic           i_job_valid,
    output logic                o_job_ready,
    wbs_res_if.source           o_res
);

    localparam int ColW = wbs_pkg::ColW;
    localparam int PosW = wbs_pkg::PosW;
    localparam int PixW = wbs_pkg::PixW;
    localparam int SumW = wbs_pkg::SumW;

    wbs_pkg::t_job          r_jb;
    logic [3:0]             r_mask;
    logic [3:0]             pick;
    logic [3:0]             rest;
    logic                   job_fire;
    logic                   emit_fire;
    logic                   e1_take;
    logic                   e2_take;

    logic                   ci2;
    logic                   cj2;
    logic [1:0]             ci_idx;
    logic [1:0]             cj_idx;
    logic [2:0]             row_ok;
    logic [2:0]             col_ok;
    logic [2:0]             rows_in;
    logic [2:0]             cols_in;
    wbs_pkg::t_pix          ctr_pix;
    logic [2:0][SumW-1:0]   sum;
    wbs_pkg::t_div          div;

    logic                   r_e1_valid;
    logic [2:0][SumW-1:0]   r_e1_sum;
    wbs_pkg::t_div          r_e1_div;
    logic [PosW-1:0]        r_e1_row;
    logic [PosW-1:0]        r_e1_col;
    logic                   r_e1_run_end;
    logic                   r_e1_frame_end;

    logic                   r_e2_valid;
    logic [PixW-1:0]        r_e2_red;
    logic [PixW-1:0]        r_e2_green;
    logic [PixW-1:0]        r_e2_blue;
    logic [PosW-1:0]        r_e2_row;
    logic [PosW-1:0]        r_e2_col;
    logic                   r_e2_run_end;
    logic                   r_e2_frame_end;

    // Stage handshakes
    assign e2_take   = !r_e2_valid || o_res.ready;
    assign e1_take   = !r_e1_valid || e2_take;

    // Emit the pending results lowest bit first
    assign pick      = r_mask & (~r_mask + 4'd1);
    assign rest      = r_mask & ~pick;
    assign emit_fire = (r_mask != '0) && e1_take;

    // Take a new job once the current one issues its last result
    assign o_job_ready = (r_mask == '0) || (emit_fire && (rest == '0));
    assign job_fire    = i_job_valid && o_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (job_fire) begin
            r_mask <= i_job.mask;
        end else if (emit_fire) begin
            r_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_fire) begin
            r_jb <= i_job;
        end
    end

    // Select the center and the in-frame neighborhood of the picked result
    always_comb begin
        ci2     = pick[2] || pick[3];
        cj2     = pick[1] || pick[3];
        ci_idx  = ci2 ? 2'd2 : 2'd1;
        cj_idx  = cj2 ? 2'd2 : 2'd1;
        row_ok  = {1'b1, r_jb.row_ok};
        col_ok  = {1'b1, r_jb.col_ok};
        rows_in = ci2 ? (row_ok & 3'b110) : row_ok;
        cols_in = cj2 ? (col_ok & 3'b110) : col_ok;
        ctr_pix = r_jb.grid[ci_idx][cj_idx];
    end

    // Sum the neighborhood per channel, center counted twice
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = SumW'(ctr_pix[ch*PixW +: PixW]);
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (rows_in[i] && cols_in[j]) begin
                        sum[ch] = sum[ch] + SumW'(r_jb.grid[i][j][ch*PixW +: PixW]);
                    end
                end
            end
        end
    end

    // Neighbor count: full 3x3 inside, 2x3 on an edge, 2x2 in a corner
    always_comb begin
        if ((&rows_in) && (&cols_in)) begin
            div = wbs_pkg::DivBy10;
        end else if ((&rows_in) || (&cols_in)) begin
            div = wbs_pkg::DivBy7;
        end else begin
            div = wbs_pkg::DivBy5;
        end
    end

    // Sum stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_valid <= 1'b0;
        end else if (e1_take) begin
            r_e1_valid <= emit_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_e1_sum       <= sum;
            r_e1_div       <= div;
            r_e1_row       <= PosW'(ci2 ? r_jb.row : r_jb.row - ColW'(1));
            r_e1_col       <= PosW'(cj2 ? r_jb.col : r_jb.col - ColW'(1));
            r_e1_run_end   <= (rest == '0);
            r_e1_frame_end <= pick[3];
        end
    end

    // Divide stage feeding the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_valid <= 1'b0;
        end else if (e2_take) begin
            r_e2_valid <= r_e1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_e1_valid && e2_take) begin
            r_e2_red       <= wbs_pkg::div_sum(r_e1_sum[2], r_e1_div);
            r_e2_green     <= wbs_pkg::div_sum(r_e1_sum[1], r_e1_div);
            r_e2_blue      <= wbs_pkg::div_sum(r_e1_sum[0], r_e1_div);
            r_e2_row       <= r_e1_row;
            r_e2_col       <= r_e1_col;
            r_e2_run_end   <= r_e1_run_end;
            r_e2_frame_end <= r_e1_frame_end;
        end
    end

    assign o_res.valid     = r_e2_valid;
    assign o_res.red_out   = r_e2_red;
    assign o_res.green_out = r_e2_green;
    assign o_res.blue_out  = r_e2_blue;
    assign o_res.out_row   = r_e2_row;
    assign o_res.out_col   = r_e2_col;
    assign o_res.run_end   = r_e2_run_end;
    assign o_res.frame_end = r_e2_frame_end;

    // The frame's final result always closes its pixel's run
    a_frame_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e2_valid && r_e2_frame_end |-> r_e2_run_end)
        else $error("frame end without run end");

    // Pending results only drain unless a new job is loaded
    a_mask_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !job_fire |=> (r_mask & ~$past(r_mask)) == '0)
        else $error("result mask grew without a new job");

endmodule

`default_nettype wire

### sv/weighted_box_smooth_3x3.sv
// Top level of the center-weighted 3x3 mean filter with its configuration register.
`timescale 1ns / 1ps
`default_nettype none

// Smooths a square RGB frame streamed in raster order: each output pixel is the truncated
// mean of its in-frame 3x3 neighborhood with the center counted twice (divide by 10 inside,
// 7 on an edge, 5 in a corner). A result leaves as soon as its last neighbor has arrived, so
// a pixel causes zero to four results, ordered by position; run_end marks the last result of
// each pixel and frame_end the frame's final pixel. A pixel that causes at most one result
// is taken every clock unless the output stalls; a pixel with several results holds the
// result sequencer until its last one issues, since the sequencer issues one result per
// clock unless the output stalls. The first result of a pixel passes the line store read,
// result sequencer, sum and divide stages. The two line stores share one 1024 x 48 memory
// with one read and one write port: read when a pixel is accepted and written back when
// that pixel moves on to the result sequencer; no clearing pass is run.
// Writing frame_side (saturated to 2..1024) restarts the frame; write it only while idle.
module weighted_box_smooth_3x3 (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    wbs_pix_if.sink                             i_pix,
    wbs_res_if.source                           o_res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [wbs_pkg::ApbAddrW-1:0]   paddr,
    input  wire logic [wbs_pkg::ApbDataW-1:0]   pwdata,
    output logic      [wbs_pkg::ApbDataW-1:0]   prdata,
    output logic                                pready
);

    localparam int SideW    = wbs_pkg::SideW;
    localparam int ColW     = wbs_pkg::ColW;
    localparam int ApbAddrW = wbs_pkg::ApbAddrW;
    localparam int ApbDataW = wbs_pkg::ApbDataW;

    logic                  reg_hit;
    logic                  restart;
    logic [SideW-1:0]      r_frame_side;
    logic [ColW-1:0]       r_last;

    wbs_pkg::t_job         job;
    logic                  job_valid;
    logic                  job_ready;

    // Register decode: one write transaction per access phase
    assign pready  = 1'b1;
    assign reg_hit = paddr[ApbAddrW-1:2] == wbs_pkg::RegFrameSide;
    assign restart = psel && penable && pwrite && pready && reg_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_side <= wbs_pkg::FrameSideReset;
            r_last       <= wbs_pkg::side_last(wbs_pkg::FrameSideReset);
        end else if (restart) begin
            r_frame_side <= pwdata[SideW-1:0];
            r_last       <= wbs_pkg::side_last(pwdata[SideW-1:0]);
        end
    end

    assign prdata = reg_hit ? ApbDataW'(r_frame_side) : '0;

    wbs_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_last      (r_last),
        .i_restart   (restart),
        .i_pix       (i_pix),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready)
    );

    wbs_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

### sim/wbs_smooth_check.sv
// Checker for the 3x3 smoothing filter: predicts results from the pixel stream and compares them.
`timescale 1ns / 1ps

module wbs_smooth_check (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    wbs_pix_if                                  i_pix,
    wbs_res_if                                  i_res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic                           pready,
    input  wire logic [wbs_pkg::ApbAddrW-1:0]   paddr,
    input  wire logic [wbs_pkg::ApbDataW-1:0]   pwdata,
    output int                                  o_mismatches,
    output int                                  o_pending
);
    import wbs_pkg::*;

    localparam logic [ApbAddrW-1:0] FrameSideAddr = ApbAddrW'(4 * RegFrameSide);

    // One smoothed pixel as it leaves the block
    typedef struct packed {
        logic [PixW-1:0] red;
        logic [PixW-1:0] green;
        logic [PixW-1:0] blue;
        logic [PosW-1:0] row;
        logic [PosW-1:0] col;
        logic            run_last;
        logic            frame_last;
    } t_smoothed;

    // Mirror of the block state
    t_pix             line_up1 [MaxSide];
    t_pix             line_up2 [MaxSide];
    t_pix             win_cols [6];       // [0..2]: column c-2, [3..5]: column c-1
    int               row_idx;
    int               col_idx;
    logic [SideW-1:0] side_reg;

    // Neighborhood of the newest pixel: nb[row][col], row 2 / col 2 newest
    t_pix             nb [3][3];
    logic [2:0]       row_ok;
    logic [2:0]       col_ok;

    t_smoothed        smoothed_due [$];

    // Last row/column index of the side in use
    function automatic int last_index();
        if (side_reg < 2) return 1;
        if (side_reg > MaxSide) return MaxSide - 1;
        return int'(side_reg) - 1;
    endfunction

    // Weighted mean around nb[ci][cj], center counted twice, out-of-frame taps dropped
    function automatic t_smoothed smooth_at(int ci, int cj, int row, int col);
        t_smoothed res;
        int        sum_r;
        int        sum_g;
        int        sum_b;
        int        taps;
        int        i;
        int        j;
        sum_r = nb[ci][cj][2*PixW +: PixW];
        sum_g = nb[ci][cj][PixW +: PixW];
        sum_b = nb[ci][cj][0 +: PixW];
        taps  = 1;
        for (int di = -1; di <= 1; di++) begin
            for (int dj = -1; dj <= 1; dj++) begin
                i = ci + di;
                j = cj + dj;
                if (i >= 0 && i <= 2 && j >= 0 && j <= 2 && row_ok[i] && col_ok[j]) begin
                    sum_r += nb[i][j][2*PixW +: PixW];
                    sum_g += nb[i][j][PixW +: PixW];
                    sum_b += nb[i][j][0 +: PixW];
                    taps++;
                end
            end
        end
        res.red        = PixW'(sum_r / taps);
        res.green      = PixW'(sum_g / taps);
        res.blue       = PixW'(sum_b / taps);
        res.row        = PosW'(row);
        res.col        = PosW'(col);
        res.run_last   = 1'b0;
        res.frame_last = 1'b0;
        return res;
    endfunction

    // Advance the mirror by one pixel and queue the results it completes
    task automatic take_pixel(input t_pix cur);
        t_smoothed batch [4];
        int        n;
        int        last;
        int        r;
        int        c;
        t_pix      above1;
        t_pix      above2;
        last = last_index();
        r    = row_idx;
        c    = col_idx;
        if (r > last || c > last) begin
            r = 0;
            c = 0;
        end

        // shift the line stores at this column
        above2      = line_up2[c];
        above1      = line_up1[c];
        line_up2[c] = above1;
        line_up1[c] = cur;

        for (int k = 0; k < 3; k++) begin
            nb[k][0] = win_cols[k];
            nb[k][1] = win_cols[3 + k];
        end
        nb[0][2] = above2;
        nb[1][2] = above1;
        nb[2][2] = cur;
        row_ok   = {1'b1, r >= 1, r >= 2};
        col_ok   = {1'b1, c >= 1, c >= 2};

        n = 0;
        if (r >= 1 && c >= 1) begin
            batch[n] = smooth_at(1, 1, r - 1, c - 1);
            n++;
        end
        if (r >= 1 && c == last) begin
            batch[n] = smooth_at(1, 2, r - 1, c);
            n++;
        end
        if (r == last && c >= 1) begin
            batch[n] = smooth_at(2, 1, r, c - 1);
            n++;
        end
        if (r == last && c == last) begin
            batch[n] = smooth_at(2, 2, r, c);
            batch[n].frame_last = 1'b1;
            n++;
        end
        if (n > 0) begin
            batch[n-1].run_last = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            smoothed_due.push_back(batch[k]);
        end

        // slide the window one column
        for (int k = 0; k < 3; k++) begin
            win_cols[k]     = nb[k][1];
            win_cols[3 + k] = nb[k][2];
        end

        if (c == last) begin
            c = 0;
            r = (r == last) ? 0 : r + 1;
        end else begin
            c++;
        end
        row_idx = r;
        col_idx = c;
    endtask

    // Watch configuration, pixel and result transactions
    always @(posedge i_clk) begin
        t_smoothed got;
        t_smoothed want;
        if (!i_rst_n) begin
            side_reg = FrameSideReset;
            row_idx  = 0;
            col_idx  = 0;
            for (int k = 0; k < 6; k++) begin
                win_cols[k] = '0;
            end
            for (int k = 0; k < MaxSide; k++) begin
                line_up1[k] = '0;
                line_up2[k] = '0;
            end
            smoothed_due.delete();
            o_mismatches = 0;
        end else begin
            // a frame_side write restarts the frame, line stores keep their contents
            if (psel && penable && pwrite && pready && paddr == FrameSideAddr) begin
                side_reg = pwdata[SideW-1:0];
                row_idx  = 0;
                col_idx  = 0;
                for (int k = 0; k < 6; k++) begin
                    win_cols[k] = '0;
                end
            end

            if (i_pix.valid && i_pix.ready) begin
                take_pixel({i_pix.red_in, i_pix.green_in, i_pix.blue_in});
            end

            if (i_res.valid && i_res.ready) begin
                got = '{i_res.red_out, i_res.green_out, i_res.blue_out, i_res.out_row,
                        i_res.out_col, i_res.run_end, i_res.frame_end};
                if (smoothed_due.size() == 0) begin
                    if (o_mismatches < 10) begin
                        $display("%0t: unexpected result rgb=%02x%02x%02x row=%0d col=%0d",
                                 $time, got.red, got.green, got.blue, got.row, got.col);
                    end
                    o_mismatches++;
                end else begin
                    want = smoothed_due.pop_front();
                    if (got !== want) begin
                        if (o_mismatches < 10) begin
                            $display("%0t: exp rgb=%02x%02x%02x row=%0d col=%0d run=%0b frm=%0b",
                                     $time, want.red, want.green, want.blue, want.row,
                                     want.col, want.run_last, want.frame_last);
                            $display("%0t: got rgb=%02x%02x%02x row=%0d col=%0d run=%0b frm=%0b",
                                     $time, got.red, got.green, got.blue, got.row,
                                     got.col, got.run_last, got.frame_last);
                        end
                        o_mismatches++;
                    end
                end
            end
        end
        o_pending = smoothed_due.size();
    end

endmodule

### sim/tb_top.sv
// Testbench top for the 3x3 smoothing filter: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;
    import wbs_pkg::*;

    localparam int IdleLimit   = 4000;
    localparam int DrainCycles = 8;
    localparam int RandomItems = 415;
    localparam logic [ApbAddrW-1:0] FrameSideAddr = ApbAddrW'(4 * RegFrameSide);

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    int                  src_idle_pct;
    int                  snk_stall_pct;
    int                  mismatches;
    int                  pending;
    int                  quiet_cycles;

    wbs_pix_if pix_bus ();
    wbs_res_if res_bus ();

    weighted_box_smooth_3x3 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    wbs_smooth_check checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_bus),
        .i_res        (res_bus),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        res_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // End the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready)
                     || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= IdleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Favor channel extremes
    function automatic logic [PixW-1:0] rand_chan();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return PixW'($urandom);
        endcase
    endfunction

    // Offer one pixel, hold it until the transaction completes
    task automatic send_pixel(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                              input logic [PixW-1:0] b);
        bit started;
        bit taken;
        started = 1'b0;
        taken   = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            if (!started && $urandom_range(99) < src_idle_pct) begin
                pix_bus.valid    <= 1'b0;
                pix_bus.red_in   <= PixW'($urandom);
                pix_bus.green_in <= PixW'($urandom);
                pix_bus.blue_in  <= PixW'($urandom);
                @(posedge i_clk);
            end else begin
                started          = 1'b1;
                pix_bus.valid    <= 1'b1;
                pix_bus.red_in   <= r;
                pix_bus.green_in <= g;
                pix_bus.blue_in  <= b;
                @(posedge i_clk);
                taken = pix_bus.ready;
            end
        end
    endtask

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++) begin
            send_pixel(rand_chan(), rand_chan(), rand_chan());
        end
    endtask

    // Drop valid and hold until every expected result is out and the pipeline is empty
    task automatic settle();
        @(negedge i_clk);
        pix_bus.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    // Setup and access phase of one register write; upper data bits are noise
    task automatic write_side(input int value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FrameSideAddr;
        pwdata  <= {(ApbDataW - SideW)'($urandom), SideW'(value)};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int sent;
        int pick;
        int side_val;
        int side_eff;
        int frames;
        int count;

        i_rst_n          = 1'b0;
        pix_bus.valid    = 1'b0;
        pix_bus.red_in   = '0;
        pix_bus.green_in = '0;
        pix_bus.blue_in  = '0;
        res_bus.ready    = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        src_idle_pct     = 0;
        snk_stall_pct    = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset side of 1024: part of row 0 only, so nothing may come out
        send_random(12);
        settle();

        // corner-only frame of full-scale pixels, then a second frame without a rewrite
        write_side(2);
        repeat (4) send_pixel('1, '1, '1);
        send_pixel('0, '0, '0);
        send_pixel('1, '1, '1);
        send_pixel(8'hff, 8'h00, 8'h80);
        send_pixel(8'h01, 8'hfe, 8'h7f);
        settle();

        // 3x3 frame covers corners, edges and the interior
        write_side(3);
        for (int k = 0; k < 9; k++) begin
            send_pixel((k % 2) ? 8'hff : 8'h00, (k % 3 == 0) ? 8'hff : 8'h00, PixW'(k * 31));
        end
        settle();

        // side below range saturates to 2
        write_side(1);
        send_random(4);
        settle();

        // random frames, rotating through the stall modes
        sent = 0;
        for (int phase = 0; sent < RandomItems; phase++) begin
            case (phase % 4)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct  = 73;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 73;
                end
                default: begin
                    src_idle_pct  = 13;
                    snk_stall_pct = 13;
                end
            endcase

            pick = $urandom_range(9);
            if (pick == 0) begin
                side_val = $urandom_range(1);
            end else if (pick == 1) begin
                side_val = $urandom_range(20, 13);
            end else begin
                side_val = $urandom_range(8, 2);
            end
            side_eff = (side_val < 2) ? 2 : side_val;
            write_side(side_val);

            frames = $urandom_range(3, 1);
            for (int f = 0; f < frames && sent < RandomItems; f++) begin
                count = side_eff * side_eff;
                // cut the last frame short now and then; the next write restarts it
                if (f == frames - 1 && $urandom_range(3) == 0) begin
                    count = $urandom_range(count - 1, 1);
                end
                // stay within the item budget
                if (count > RandomItems - sent) begin
                    count = RandomItems - sent;
                end
                send_random(count);
                sent += count;
                if ($urandom_range(2) == 0) begin
                    settle();
                end
            end
            settle();
        end

        // side above range saturates to 1024: again part of row 0 only
        src_idle_pct  = 13;
        snk_stall_pct = 13;
        write_side(2047);
        send_random(12);
        settle();

        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
